@@ design/uniform_bin_histogram_assert.svh @@
// assertion macros for the histogram engine checker
// depends on nothing; included by the checker file
`ifndef UNIFORM_BIN_HISTOGRAM_ASSERT_SVH
`define UNIFORM_BIN_HISTOGRAM_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define UBH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("histogram check failed");

// next-cycle implication, checked on every rising edge outside reset
`define UBH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("histogram check failed");

`endif

@@ design/ubh_pkg.sv @@
// shared constants, codes and types of the uniform-bin histogram engine
// depends on nothing
`default_nettype none

package ubh_pkg;

	// counter store size and derived widths
	localparam int BINS       = 16;
	localparam int IDX_W      = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int CNT_W      = $clog2(BINS + 1);
	localparam int VAL_W      = 16;
	localparam int USED_W     = 7;
	localparam int TOT_W      = 32;
	localparam int OUT_IDX_W  = 6;
	localparam int BND_W      = VAL_W + 1 + $clog2(BINS + 1);
	localparam int OUT_DATA_W = ((OUT_IDX_W + TOT_W + 7) / 8) * 8;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// reset values of the configuration registers
	localparam logic [VAL_W-1:0]  MIN_RESET   = 16'd0;
	localparam logic [VAL_W-1:0]  WIDTH_RESET = 16'd256;
	localparam logic [USED_W-1:0] USED_RESET  = 7'd16;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 2'd0,
		OP_DUMP  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN   = 2'd0,
		REG_WIDTH = 2'd1,
		REG_USED  = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_LOOKUP,
		ST_UPDATE,
		ST_DUMP_RD,
		ST_DUMP_OUT
	} state_t;

	// access request to the counter memory
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [TOT_W-1:0] wr_data;
		logic             clear;
	} ram_req_t;

endpackage

`default_nettype wire

@@ design/ubh_bin_search.sv @@
// bin search: one comparator per bin against its upper bound, registered flags,
// then a priority encoder; depends on ubh_pkg
`default_nettype none

module ubh_bin_search (
	input  wire logic                       clk,
	input  wire logic                       flag_load,
	input  wire logic [ubh_pkg::VAL_W-1:0]  sample,
	input  wire logic [ubh_pkg::VAL_W-1:0]  min_value,
	input  wire logic [ubh_pkg::VAL_W-1:0]  bin_step,
	input  wire logic [ubh_pkg::CNT_W-1:0]  n_active,
	output logic      [ubh_pkg::IDX_W-1:0]  bin
);
	import ubh_pkg::*;

	logic [BND_W-1:0] bound [BINS];
	logic [BINS-1:0]  le;
	logic [BINS-1:0]  le_q;

	// upper bound of each bin and the at-or-below flag, bins past the used range masked
	always_comb begin
		for (int b = 0; b < BINS; b++) begin
			bound[b] = BND_W'(min_value) + BND_W'(bin_step) * BND_W'(b + 1);
			le[b]    = (BND_W'(sample) <= bound[b]) && (CNT_W'(b) < n_active);
		end
	end

	// flags held for the encoder
	always_ff @(posedge clk) begin
		if (flag_load) begin
			le_q <= le;
		end
	end

	// lowest flagged bin, else the last bin in use
	always_comb begin
		bin = IDX_W'(n_active - CNT_W'(1));
		for (int b = BINS - 1; b >= 0; b--) begin
			if (le_q[b]) begin
				bin = IDX_W'(b);
			end
		end
	end

endmodule

`default_nettype wire

@@ design/ubh_count_ram.sv @@
// counter memory: one write and one registered read a cycle, valid bits per entry
// so that reset and clear take effect at once; depends on ubh_pkg
`default_nettype none

module ubh_count_ram (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire ubh_pkg::ram_req_t         req,
	output logic      [ubh_pkg::TOT_W-1:0] rd_data
);
	import ubh_pkg::*;

	logic [TOT_W-1:0] mem [BINS];
	logic [TOT_W-1:0] data_q;
	logic [BINS-1:0]  valid_q;
	logic             hit_q;

	// storage array and registered read port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			data_q <= mem[req.rd_addr];
		end
	end

	// entry valid bits, dropped together on reset or clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				hit_q <= valid_q[req.rd_addr];
			end
		end
	end

	// an entry never written since the last clear reads as zero
	assign rd_data = hit_q ? data_q : '0;

endmodule

`default_nettype wire

@@ design/uniform_bin_histogram.sv @@
// Uniform-bin histogram engine. An add word (tuser 0) steps through search, lookup and update: the bin is
// found by one comparator per bin against min_value + bin_step*(b+1) with the flags registered, then the
// counter is read from the counter memory, incremented with saturation and written back. A dump word
// (tuser 1) emits one word per bin in use, bin 0 first, each by a read and then a load of the output
// register, tlast on the final bin; a receiver stall holds the dump. A clear word (tuser 2) and an unused
// code are handled in the idle state. Counters are zero after reset and need no clearing pass.
// Configuration writes are taken at any time and must only be made while idle.
// depends on ubh_pkg, ubh_bin_search, ubh_count_ram
`default_nettype none

module uniform_bin_histogram (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input words
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [ubh_pkg::VAL_W-1:0]           s_tdata,   // [15:0] sample
	input  wire logic [ubh_pkg::OP_W-1:0]            s_tuser,   // [1:0] op
	// result words
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [ubh_pkg::OUT_DATA_W-1:0]      m_tdata,   // [5:0] bin_index, [37:6] bin_total, rest zero
	output logic                                     m_tlast,
	// configuration writes
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ubh_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [ubh_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ubh_pkg::*;

	logic [VAL_W-1:0]  min_value_q;
	logic [VAL_W-1:0]  bin_step_q;
	logic [USED_W-1:0] bins_used_q;
	logic [CNT_W-1:0]  n_active;

	state_t            state_q;
	state_t            state_d;
	logic [VAL_W-1:0]  sample_q;
	logic [IDX_W-1:0]  bin_q;
	logic [IDX_W-1:0]  dump_q;
	logic [IDX_W-1:0]  bin_found;
	logic [TOT_W-1:0]  rd_data;
	ram_req_t          req;

	logic              accept;
	logic              flag_load;
	logic              out_free;
	logic              out_load;
	logic              dump_last;

	logic              out_valid_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [TOT_W-1:0]  out_tot_q;
	logic              out_last_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_value_q <= MIN_RESET;
			bin_step_q  <= WIDTH_RESET;
			bins_used_q <= USED_RESET;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_MIN:   min_value_q <= cfg_data;
				REG_WIDTH: bin_step_q  <= cfg_data;
				REG_USED:  bins_used_q <= cfg_data[USED_W-1:0];
				default: ;
			endcase
		end
	end

	// bins in use, clamped to one..BINS
	always_comb begin
		if (bins_used_q > USED_W'(BINS)) begin
			n_active = CNT_W'(BINS);
		end else if (bins_used_q == '0) begin
			n_active = CNT_W'(1);
		end else begin
			n_active = CNT_W'(bins_used_q);
		end
	end

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign dump_last = (CNT_W'(dump_q) + CNT_W'(1)) == n_active;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op_t'(s_tuser))
						OP_ADD:  state_d = ST_SEARCH;
						OP_DUMP: state_d = ST_DUMP_RD;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SEARCH:   state_d = ST_LOOKUP;
			ST_LOOKUP:   state_d = ST_UPDATE;
			ST_UPDATE:   state_d = ST_IDLE;
			ST_DUMP_RD:  state_d = ST_DUMP_OUT;
			ST_DUMP_OUT: begin
				if (out_free) begin
					state_d = dump_last ? ST_IDLE : ST_DUMP_RD;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// control outputs of the sequencer
	always_comb begin
		s_tready    = 1'b0;
		flag_load   = 1'b0;
		out_load    = 1'b0;
		req         = '0;
		req.rd_addr = dump_q;
		req.wr_addr = bin_q;
		req.wr_data = (rd_data == '1) ? rd_data : rd_data + TOT_W'(1);
		case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				req.clear = s_tvalid && (op_t'(s_tuser) == OP_CLEAR);
			end
			ST_SEARCH:   flag_load = 1'b1;
			ST_LOOKUP: begin
				req.rd_en   = 1'b1;
				req.rd_addr = bin_found;
			end
			ST_UPDATE:   req.wr_en = 1'b1;
			ST_DUMP_RD:  req.rd_en = 1'b1;
			ST_DUMP_OUT: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// item and bin registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= s_tdata;
			dump_q   <= '0;
		end else if (out_load) begin
			dump_q   <= dump_q + IDX_W'(1);
		end
		if (state_q == ST_LOOKUP) begin
			bin_q <= bin_found;
		end
	end

	ubh_bin_search u_search (
		.clk       (clk),
		.flag_load (flag_load),
		.sample    (sample_q),
		.min_value (min_value_q),
		.bin_step  (bin_step_q),
		.n_active  (n_active),
		.bin       (bin_found)
	);

	ubh_count_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q  <= dump_q;
			out_tot_q  <= rd_data;
			out_last_q <= dump_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUT_DATA_W'({out_tot_q, OUT_IDX_W'(out_idx_q)});

endmodule

`default_nettype wire

@@ design/ubh_checker.sv @@
// port-level checker for the histogram engine, bound to the top level
// depends on ubh_pkg and uniform_bin_histogram_assert.svh
`default_nettype none
`include "uniform_bin_histogram_assert.svh"

module ubh_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tready,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [ubh_pkg::OUT_DATA_W-1:0] m_tdata,
	input wire logic                           m_tlast
);
	import ubh_pkg::*;

	// a stalled result word holds
	`UBH_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// no new input word while a dump still has words to come
	`UBH_ASSERT_NOW(a_dump_blocks_input, clk, arst_n, m_tvalid && !m_tlast, !s_tready)

	// a word after the end of a dump starts the next dump at bin zero
	`UBH_ASSERT_NEXT(a_dump_restarts, clk, arst_n, m_tvalid && m_tready && m_tlast, !m_tvalid || (m_tdata[OUT_IDX_W-1:0] == '0))

	// padding above the packed fields stays zero
	`UBH_ASSERT_NOW(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[OUT_DATA_W-1:OUT_IDX_W+TOT_W] == '0)

endmodule

bind uniform_bin_histogram ubh_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// self-checking bench for the uniform-bin histogram engine: directed table, then random words
// predicts bin counts and dump reports from its own copy of counters and registers
// depends on ubh_pkg and uniform_bin_histogram
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ubh_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int SETTLE      = 8;     // cycles for an add word to finish inside the engine
	localparam int TAIL        = 40;
	localparam int QUIET_LIMIT = 5000;
	localparam int PAD_LO      = OUT_IDX_W + TOT_W;
	localparam int MAX_PRINT   = 20;

	// codes with no meaning to the engine
	localparam logic [OP_W-1:0]      OP_RESERVED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [VAL_W-1:0]      s_tdata;   // [15:0] sample
	logic [OP_W-1:0]       s_tuser;   // [1:0] op
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // [5:0] bin_index, [37:6] bin_total, rest zero
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	uniform_bin_histogram DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// one reported bin of a dump
	typedef struct packed {
		logic [OUT_IDX_W-1:0] idx;
		logic [TOT_W-1:0]     total;
		logic                 tail;
	} bin_report_t;

	// directed table row: a register write or an input word
	typedef enum bit {ROW_REG, ROW_WORD} row_kind_t;
	typedef struct packed {
		row_kind_t        kind;
		logic [1:0]       code;
		logic [15:0]      val;
		bit               known;   // every reported total equals total
		logic [TOT_W-1:0] total;
	} plan_row_t;

	// engine image: registers and counters
	logic [VAL_W-1:0]  lo_edge;
	logic [VAL_W-1:0]  step_w;
	logic [USED_W-1:0] used_reg;
	logic [TOT_W-1:0]  tally [BINS];

	bin_report_t reports_due [$];
	plan_row_t   plan [$];

	int src_idle;
	int sink_idle;
	int errors;
	int words_sent;
	int dumps_sent;
	int reports_checked;
	int reg_writes;
	int quiet;

	// number of bins the dump walks and the search covers
	function automatic int span_bins();
		int n;
		n = used_reg;
		if (n > BINS)
			n = BINS;
		if (n == 0)
			n = 1;
		return n;
	endfunction

	// first bin whose upper edge is at or above the sample
	function automatic int pick_bin(logic [VAL_W-1:0] v);
		int n;
		longint unsigned top;
		n = span_bins();
		for (int b = 0; b < n; b++) begin
			top = 64'(lo_edge) + 64'(step_w) * 64'(b + 1);
			if (64'(v) <= top)
				return b;
		end
		return n - 1;
	endfunction

	task automatic set_image_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_MIN:   lo_edge = data;
			REG_WIDTH: step_w = data;
			REG_USED:  used_reg = data[USED_W-1:0];
			default: ;
		endcase
	endtask

	// update the image for one accepted word and queue any dump reports
	task automatic tally_word(logic [OP_W-1:0] op, logic [VAL_W-1:0] smp, bit known,
			logic [TOT_W-1:0] ktot);
		int b;
		int n;
		bin_report_t r;
		case (op)
			OP_ADD: begin
				b = pick_bin(smp);
				if (tally[b] != 32'hFFFF_FFFF)
					tally[b] = tally[b] + 1;
			end
			OP_DUMP: begin
				n = span_bins();
				dumps_sent++;
				for (int i = 0; i < n; i++) begin
					r.idx   = OUT_IDX_W'(i);
					r.total = known ? ktot : tally[i];
					r.tail  = (i == n - 1);
					reports_due.push_back(r);
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < BINS; i++)
					tally[i] = '0;
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (errors < MAX_PRINT)
			$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// present one word with random sender gaps, record it when taken
	task automatic put_word(logic [OP_W-1:0] op, logic [VAL_W-1:0] smp, bit known = 1'b0,
			logic [TOT_W-1:0] ktot = '0);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= smp;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tally_word(op, smp, known, ktot);
		words_sent++;
		@(negedge clk);
	endtask

	// register write, only once the engine has gone quiet
	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		s_tvalid <= 1'b0;
		while (reports_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		set_image_reg(idx, data);
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_row(row_kind_t k, logic [1:0] c, logic [15:0] v, bit kn = 1'b0,
			logic [TOT_W-1:0] t = '0);
		plan_row_t r;
		r = '{kind: k, code: c, val: v, known: kn, total: t};
		plan.push_back(r);
	endtask

	// random setting with the extremes weighted in, then a burst of words
	task automatic run_phase(int src_pct, int snk_pct, int n_words);
		logic [VAL_W-1:0] v;
		logic [CFG_DATA_W-1:0] d;
		longint unsigned sum;
		int n;
		int pick;
		case ($urandom_range(3))
			0:       d = 16'h0000;
			1:       d = 16'hFFFF;
			default: d = 16'($urandom_range(0, 16'hFFFF));
		endcase
		put_reg(REG_MIN, d);
		case ($urandom_range(5))
			0:       d = 16'h0000;
			1:       d = 16'h0001;
			2:       d = 16'hFFFF;
			default: d = 16'($urandom_range(1, 16'h0800));
		endcase
		put_reg(REG_WIDTH, d);
		case ($urandom_range(4))
			0:       d = 16'd0;
			1:       d = 16'h007F;
			2:       d = 16'(BINS);
			default: d = 16'($urandom_range(1, 20));
		endcase
		put_reg(REG_USED, d);
		src_idle  = src_pct;
		sink_idle = snk_pct;
		for (int w = 0; w < n_words; w++) begin
			pick = $urandom_range(99);
			n = span_bins();
			if (pick < 84) begin
				// mostly samples around the bins in use, some on an edge, some anywhere
				if (pick < 55)
					sum = 64'(lo_edge) + 64'($urandom_range(0, 32'(step_w) * (n + 1)));
				else if (pick < 70)
					sum = 64'(lo_edge) + 64'(step_w) * 64'($urandom_range(0, n))
						+ 64'($urandom_range(0, 1));
				else
					sum = 64'($urandom_range(0, 16'hFFFF));
				v = (sum > 64'hFFFF) ? 16'hFFFF : sum[15:0];
				put_word(OP_ADD, v);
			end else if (pick < 93) begin
				put_word(OP_DUMP, 16'($urandom_range(0, 16'hFFFF)));
			end else if (pick < 97) begin
				put_word(OP_CLEAR, 16'($urandom_range(0, 16'hFFFF)));
			end else begin
				put_word(OP_RESERVED, 16'($urandom_range(0, 16'hFFFF)));
			end
		end
		put_word(OP_DUMP, 16'h0000);
	endtask

	// free-running clock
	always #(HALF_PERIOD) clk = ~clk;

	// receiver stalls
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle);
	end

	// check every reported bin against the oldest one due
	always @(posedge clk) begin : check_reports
		bin_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (reports_due.size() == 0) begin
				report_mismatch("report with none due", 64'(m_tdata), 64'd0);
			end else begin
				want = reports_due.pop_front();
				if (m_tdata[OUT_IDX_W-1:0] != want.idx)
					report_mismatch("bin_index", 64'(m_tdata[OUT_IDX_W-1:0]), 64'(want.idx));
				if (m_tdata[PAD_LO-1:OUT_IDX_W] != want.total)
					report_mismatch("bin_total", 64'(m_tdata[PAD_LO-1:OUT_IDX_W]),
						64'(want.total));
				if (m_tlast != want.tail)
					report_mismatch("tlast", 64'(m_tlast), 64'(want.tail));
				if ((m_tdata >> PAD_LO) != '0)
					report_mismatch("tdata padding", 64'(m_tdata >> PAD_LO), 64'd0);
				reports_checked++;
			end
		end
	end

	// watchdog on cycles with no word moving anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("timeout: nothing moved for %0d cycles", quiet);
			$display("FAIL uniform_bin_histogram");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = OP_ADD;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MIN;
		cfg_data  = '0;
		errors = 0;
		words_sent = 0;
		dumps_sent = 0;
		reports_checked = 0;
		reg_writes = 0;
		quiet = 0;
		src_idle  = 11;
		sink_idle = 78;
		lo_edge  = MIN_RESET;
		step_w   = WIDTH_RESET;
		used_reg = USED_RESET;
		for (int i = 0; i < BINS; i++)
			tally[i] = '0;

		// directed table
		add_row(ROW_WORD, OP_DUMP, 16'h0000, 1'b1, 32'd0);   // counters zero out of reset
		add_row(ROW_WORD, OP_ADD, 16'h0000);
		add_row(ROW_WORD, OP_ADD, 16'hFFFF);                 // above the top bin
		add_row(ROW_WORD, OP_ADD, 16'h0100);                 // exactly on bin 0 upper edge
		add_row(ROW_WORD, OP_ADD, 16'h0101);
		add_row(ROW_WORD, OP_ADD, 16'h8000);
		add_row(ROW_WORD, OP_RESERVED, 16'hFFFF);            // unused op, ignored
		add_row(ROW_WORD, OP_DUMP, 16'h0000);
		add_row(ROW_WORD, OP_CLEAR, 16'h5A5A);
		add_row(ROW_WORD, OP_DUMP, 16'hFFFF, 1'b1, 32'd0);   // everything zero after clear
		add_row(ROW_REG, REG_MIN, 16'hFFFF);
		add_row(ROW_REG, REG_WIDTH, 16'hFFFF);
		add_row(ROW_REG, REG_USED, 16'hFF40);                // 64 once masked, clamps to all
		add_row(ROW_WORD, OP_ADD, 16'h0000);                 // below the minimum
		add_row(ROW_WORD, OP_ADD, 16'hFFFF);
		add_row(ROW_WORD, OP_DUMP, 16'h0000);
		add_row(ROW_REG, REG_MIN, 16'h1234);
		add_row(ROW_REG, REG_WIDTH, 16'h0000);               // zero width, all edges at min
		add_row(ROW_REG, REG_USED, 16'd5);
		add_row(ROW_WORD, OP_ADD, 16'h1234);
		add_row(ROW_WORD, OP_ADD, 16'h1235);
		add_row(ROW_WORD, OP_DUMP, 16'h0000);
		add_row(ROW_REG, REG_USED, 16'd0);                   // zero bins acts as one
		add_row(ROW_REG, REG_SPARE, 16'hFFFF);               // unused index, no effect
		add_row(ROW_WORD, OP_DUMP, 16'h0000);

		// reset, released on a falling edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG)
				put_reg(plan[i].code, plan[i].val);
			else
				put_word(plan[i].code, plan[i].val, plan[i].known, plan[i].total);
		end

		// random words under the three idle mixes
		run_phase(11, 78, 60);
		run_phase(78, 11, 60);
		run_phase(0, 0, 60);

		// drain
		s_tvalid <= 1'b0;
		while (reports_due.size() != 0)
			@(negedge clk);
		repeat (TAIL) @(negedge clk);

		$display("sent %0d words (%0d dumps) over %0d register writes", words_sent, dumps_sent,
			reg_writes);
		$display("checked %0d bin reports, %0d mismatches", reports_checked, errors);
		if (errors == 0)
			$display("PASS uniform_bin_histogram");
		else
			$display("FAIL uniform_bin_histogram");
		$finish;
	end

endmodule
